// ===== design/assert_macros.svh =====
// Assertion macros shared by the reassembler RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/canseg_pkg.sv =====
// Package for the CAN segment reassembler: frame and chunk payload types and
// protocol constants. Depends on nothing.
package canseg_pkg;

	// One input transfer: a command and a CAN frame.
	typedef struct packed {
		logic        cmd;
		logic [28:0] frame_id;
		logic [3:0]  frame_len;
		logic [7:0]  data_0;
		logic [7:0]  data_1;
		logic [7:0]  data_2;
		logic [7:0]  data_3;
		logic [7:0]  data_4;
		logic [7:0]  data_5;
		logic [7:0]  data_6;
		logic [7:0]  data_7;
	} frame_t;

	// One output transfer: up to eight bytes of a completed message.
	typedef struct packed {
		logic [7:0] out_byte_0;
		logic [7:0] out_byte_1;
		logic [7:0] out_byte_2;
		logic [7:0] out_byte_3;
		logic [7:0] out_byte_4;
		logic [7:0] out_byte_5;
		logic [7:0] out_byte_6;
		logic [7:0] out_byte_7;
		logic [3:0] chunk_count;
		logic       last_chunk;
		logic [8:0] message_length;
	} chunk_t;

	// Command codes.
	localparam logic CMD_FEED  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Segment byte codes.
	localparam logic [7:0] SEG_START  = 8'h00;
	localparam logic [7:0] SEG_SINGLE = 8'hFF;

	// Declared length field and frame layout.
	localparam logic [10:0] LEN_MASK    = 11'h7FF;
	localparam logic [3:0]  START_HDR   = 4'd3;
	localparam logic [3:0]  CONT_HDR    = 4'd1;
	localparam logic [3:0]  FRAME_BYTES = 4'd8;
	localparam logic [3:0]  CHUNK_BYTES = 4'd8;

endpackage

// ===== design/can_segment_reassembler.sv =====
// CAN segmented message reassembler: slot table, payload store and sequencer.
// Depends on canseg_pkg and assert_macros.svh.
//
// A frame is captured, its slot is chosen, each payload byte (up to seven) is
// appended in turn and completion is then tested; a clear command or a frame
// that is dropped returns to idle straight after the slot is chosen.
// A completed message of n bytes then goes out as chunks of eight; each
// chunk reads its bytes one by one from the payload store, lets the last
// read land and waits until the output register is free or being emptied.
// A new frame is accepted once the last chunk sits in the output register.
// Slot state lives in flip-flops; the payload bytes live in a byte-wide
// memory of 2**(clog2(SLOTS) + clog2(MAX_PAYLOAD)) entries that needs no
// clearing after reset.
`include "assert_macros.svh"

module can_segment_reassembler #(
	parameter int SLOTS       = 6,
	parameter int MAX_PAYLOAD = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_ready,
	input  canseg_pkg::frame_t  frame,
	output logic                chunk_valid,
	input  logic                chunk_ready,
	output canseg_pkg::chunk_t  chunk
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OFF_W  = $clog2(MAX_PAYLOAD);
	localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = SLOT_W + OFF_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam logic [FILL_W-1:0] CAP     = FILL_W'(MAX_PAYLOAD);
	localparam logic [10:0]       CAP_LEN = 11'(MAX_PAYLOAD);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_APPEND = 7'b0000100,
		ST_CHECK  = 7'b0001000,
		ST_RD     = 7'b0010000,
		ST_LAND   = 7'b0100000,
		ST_PUT    = 7'b1000000
	} state_t;

	state_t                state_q;
	canseg_pkg::frame_t    frm_q;
	logic [3:0]            len_q;
	logic [3:0]            byte_idx_q;
	logic [SLOT_W-1:0]     act_q;

	logic [28:0]           slot_key_q  [SLOTS];
	logic                  slot_busy_q [SLOTS];
	logic [7:0]            slot_next_q [SLOTS];
	logic [FILL_W-1:0]     slot_decl_q [SLOTS];
	logic [FILL_W-1:0]     slot_fill_q [SLOTS];

	logic [7:0]            payload_store [DEPTH];
	logic [7:0]            mem_rd_q;
	logic                  rd_pend_q;
	logic [2:0]            rd_idx_q;
	logic [2:0]            rd_j_q;
	logic [FILL_W-1:0]     pos_q;
	logic [7:0]            buf_q [8];

	canseg_pkg::chunk_t    chunk_q;
	logic                  chunk_valid_q;

	logic [7:0]            fbyte [8];
	logic [SLOTS-1:0]      hit_vec;
	logic                  hit_found;
	logic [SLOT_W-1:0]     hit_idx;
	logic                  free_found;
	logic [SLOT_W-1:0]     free_idx;
	logic [SLOT_W-1:0]     start_idx;
	logic [10:0]           total;
	logic                  total_ok;
	logic [FILL_W-1:0]     act_fill;
	logic [FILL_W-1:0]     act_decl;
	logic                  mem_we;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [FILL_W-1:0]     rd_off;
	logic [FILL_W-1:0]     rem;
	logic [3:0]            cnt;
	logic                  last;
	logic                  put_go;
	logic [7:0]            obyte [8];

	// Frame bytes as an indexable row.
	assign fbyte[0] = frm_q.data_0;
	assign fbyte[1] = frm_q.data_1;
	assign fbyte[2] = frm_q.data_2;
	assign fbyte[3] = frm_q.data_3;
	assign fbyte[4] = frm_q.data_4;
	assign fbyte[5] = frm_q.data_5;
	assign fbyte[6] = frm_q.data_6;
	assign fbyte[7] = frm_q.data_7;

	// Slot lookup: lowest busy slot with a matching key, and lowest free slot.
	always_comb begin
		hit_found  = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			hit_vec[s] = slot_busy_q[s] && (slot_key_q[s] == frm_q.frame_id);
			if (hit_vec[s]) begin
				hit_found = 1'b1;
				hit_idx   = SLOT_W'(s);
			end
			if (!slot_busy_q[s]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(s);
			end
		end
	end

	// A start frame reuses its own slot, else a free one, else evicts slot zero.
	assign start_idx = hit_found ? hit_idx : (free_found ? free_idx : '0);
	assign total     = 11'({frm_q.data_1, frm_q.data_2}) & canseg_pkg::LEN_MASK;
	assign total_ok  = (total != 11'd0) && (total <= CAP_LEN);

	// Active slot view.
	assign act_fill = slot_fill_q[act_q];
	assign act_decl = slot_decl_q[act_q];

	// Store write port: one appended byte per cycle, dropped at capacity.
	assign mem_we  = (state_q == ST_APPEND) && (act_fill < CAP);
	assign wr_addr = {act_q, act_fill[OFF_W-1:0]};

	// Store read port and chunk geometry.
	assign rd_off  = pos_q + FILL_W'(rd_j_q);
	assign rd_addr = {act_q, rd_off[OFF_W-1:0]};
	assign rem     = act_decl - pos_q;
	assign cnt     = (rem >= FILL_W'(canseg_pkg::CHUNK_BYTES)) ? canseg_pkg::CHUNK_BYTES
	                                                          : rem[3:0];
	assign last    = (rem <= FILL_W'(canseg_pkg::CHUNK_BYTES));
	assign put_go  = (state_q == ST_PUT) && (!chunk_valid_q || chunk_ready);

	// Bytes past the chunk count read as zero.
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			obyte[j] = (4'(j) < cnt) ? buf_q[j] : 8'h00;
		end
	end

	// Payload store, written and read in clocked blocks.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			payload_store[wr_addr] <= fbyte[byte_idx_q[2:0]];
		end
		if (state_q == ST_RD) begin
			mem_rd_q <= payload_store[rd_addr];
		end
	end

	// Chunk gather buffer: each read byte passes through mem_rd_q before it is written at its index.
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			buf_q[rd_idx_q] <= mem_rd_q;
		end
		rd_idx_q <= rd_j_q;
	end

	// Frame capture and chunk payload registers.
	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			frm_q <= frame;
			len_q <= (frame.frame_len > canseg_pkg::FRAME_BYTES) ? canseg_pkg::FRAME_BYTES
			                                                    : frame.frame_len;
		end
		if (put_go) begin
			chunk_q.out_byte_0     <= obyte[0];
			chunk_q.out_byte_1     <= obyte[1];
			chunk_q.out_byte_2     <= obyte[2];
			chunk_q.out_byte_3     <= obyte[3];
			chunk_q.out_byte_4     <= obyte[4];
			chunk_q.out_byte_5     <= obyte[5];
			chunk_q.out_byte_6     <= obyte[6];
			chunk_q.out_byte_7     <= obyte[7];
			chunk_q.chunk_count    <= cnt;
			chunk_q.last_chunk     <= last;
			chunk_q.message_length <= 9'(act_decl);
		end
	end

	// Sequencer and slot table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			act_q         <= '0;
			byte_idx_q    <= '0;
			pos_q         <= '0;
			rd_j_q        <= '0;
			rd_pend_q     <= 1'b0;
			chunk_valid_q <= 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				slot_key_q[s]  <= '0;
				slot_busy_q[s] <= 1'b0;
				slot_next_q[s] <= '0;
				slot_decl_q[s] <= '0;
				slot_fill_q[s] <= '0;
			end
		end else begin
			rd_pend_q <= (state_q == ST_RD);
			// Output register: loaded by the sequencer, emptied by a transfer.
			if (put_go) begin
				chunk_valid_q <= 1'b1;
			end else if (chunk_ready) begin
				chunk_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (frame_valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (frm_q.cmd == canseg_pkg::CMD_CLEAR) begin
						for (int s = 0; s < SLOTS; s++) begin
							slot_busy_q[s] <= 1'b0;
							slot_next_q[s] <= '0;
							slot_decl_q[s] <= '0;
							slot_fill_q[s] <= '0;
						end
						state_q <= ST_IDLE;
					end else if (len_q == 4'd0 || frm_q.data_0 == canseg_pkg::SEG_SINGLE) begin
						state_q <= ST_IDLE;
					end else if (frm_q.data_0 == canseg_pkg::SEG_START) begin
						if (len_q < canseg_pkg::START_HDR || !total_ok) begin
							state_q <= ST_IDLE;
						end else begin
							act_q                  <= start_idx;
							slot_key_q[start_idx]  <= frm_q.frame_id;
							slot_busy_q[start_idx] <= 1'b1;
							slot_next_q[start_idx] <= 8'd1;
							slot_decl_q[start_idx] <= total[FILL_W-1:0];
							slot_fill_q[start_idx] <= '0;
							byte_idx_q             <= canseg_pkg::START_HDR;
							state_q <= (len_q > canseg_pkg::START_HDR) ? ST_APPEND : ST_CHECK;
						end
					end else if (!hit_found) begin
						state_q <= ST_IDLE;
					end else if (frm_q.data_0 != slot_next_q[hit_idx]) begin
						// Out-of-order segment drops the stream.
						slot_busy_q[hit_idx] <= 1'b0;
						slot_next_q[hit_idx] <= '0;
						slot_decl_q[hit_idx] <= '0;
						slot_fill_q[hit_idx] <= '0;
						state_q              <= ST_IDLE;
					end else begin
						act_q                <= hit_idx;
						slot_next_q[hit_idx] <= frm_q.data_0 + 8'd1;
						byte_idx_q           <= canseg_pkg::CONT_HDR;
						state_q <= (len_q > canseg_pkg::CONT_HDR) ? ST_APPEND : ST_CHECK;
					end
				end
				ST_APPEND: begin
					if (mem_we) begin
						slot_fill_q[act_q] <= act_fill + FILL_W'(1);
					end
					byte_idx_q <= byte_idx_q + 4'd1;
					if (byte_idx_q + 4'd1 == len_q) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					pos_q  <= '0;
					rd_j_q <= '0;
					state_q <= (act_fill >= act_decl) ? ST_RD : ST_IDLE;
				end
				ST_RD: begin
					if ({1'b0, rd_j_q} + 4'd1 == cnt) begin
						state_q <= ST_LAND;
					end else begin
						rd_j_q <= rd_j_q + 3'd1;
					end
				end
				ST_LAND: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (put_go) begin
						if (last) begin
							slot_busy_q[act_q] <= 1'b0;
							slot_next_q[act_q] <= '0;
							slot_decl_q[act_q] <= '0;
							slot_fill_q[act_q] <= '0;
							state_q            <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + FILL_W'(canseg_pkg::CHUNK_BYTES);
							rd_j_q  <= '0;
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign frame_ready = (state_q == ST_IDLE);
	assign chunk_valid = chunk_valid_q;
	assign chunk       = chunk_q;

	// Checks on the sequencer, slot table and chunk format.
	`ASSERT_ALWAYS(a_fill_cap, clk, arst_n, slot_fill_q[act_q] <= CAP, "slot fill above capacity")
	`ASSERT_IMPLIES(a_pend_rd, clk, arst_n, rd_pend_q, $past(state_q == ST_RD), "stray read data")
	`ASSERT_IMPLIES(a_put_busy, clk, arst_n, state_q == ST_PUT, slot_busy_q[act_q], "emit from free slot")
	`ASSERT_IMPLIES(a_chunk_fmt, clk, arst_n, chunk_valid, (chunk.chunk_count != 4'd0) && (chunk.last_chunk || chunk.chunk_count == 4'd8), "bad chunk count")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for can_segment_reassembler: directed frames, random streams, then one long stream.
// Depends on canseg_pkg; predicts every output chunk with a local model of the slot table.
module testbench;

	localparam int SLOTS        = 6;
	localparam int MAX_PAYLOAD  = 256;
	localparam int RANDOM_ITEMS = 150;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 64;

	typedef struct {
		canseg_pkg::frame_t f;
		bit                 typed;
		canseg_pkg::chunk_t c;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               frame_valid;
	logic               frame_ready;
	canseg_pkg::frame_t frame;
	logic               chunk_valid;
	logic               chunk_ready;
	canseg_pkg::chunk_t chunk;

	// Local copy of the slot table and payload store.
	logic [28:0] stream_id [SLOTS];
	logic        stream_open [SLOTS];
	logic [7:0]  seg_expected [SLOTS];
	logic [8:0]  msg_len [SLOTS];
	logic [8:0]  msg_fill [SLOTS];
	logic [7:0]  msg_bytes [SLOTS][MAX_PAYLOAD];

	canseg_pkg::chunk_t pending_chunks[$];
	stim_row_t   directed_rows[$];
	logic [28:0] id_pool [8];
	int          mismatch_count = 0;
	int          frames_sent = 0;
	int          tx_calm = 0;
	int          rx_calm = 0;
	int          rx_hold = 0;
	bit          long_hold_req = 1'b0;

	can_segment_reassembler #(
		.SLOTS(SLOTS),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame(frame),
		.chunk_valid(chunk_valid),
		.chunk_ready(chunk_ready),
		.chunk(chunk)
	);

	always #4 clk = ~clk;

	function automatic canseg_pkg::frame_t make_frame(logic c, logic [28:0] id,
			logic [3:0] len, logic [63:0] bytes);
		return {c, id, len, bytes};
	endfunction

	function automatic canseg_pkg::chunk_t make_chunk(logic [63:0] bytes, logic [3:0] cnt,
			logic last, logic [8:0] mlen);
		return {bytes, cnt, last, mlen};
	endfunction

	function automatic logic [28:0] pick_id();
		if ($urandom_range(0, 9) < 7)
			return id_pool[$urandom_range(0, 7)];
		return 29'($urandom);
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch with none.
	task automatic pick_gap(inout int calm, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if (r < 3) begin
			calm = $urandom_range(10, 30);
			gap = 0;
		end else if (r < 45) begin
			gap = 0;
		end else if (r < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 60);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic release_slot(input int s);
		stream_open[s] = 1'b0;
		msg_fill[s] = '0;
		msg_len[s] = '0;
		seg_expected[s] = '0;
	endtask

	function automatic int find_stream(logic [28:0] id);
		for (int s = 0; s < SLOTS; s++)
			if (stream_open[s] && stream_id[s] == id)
				return s;
		return -1;
	endfunction

	task automatic append_byte(input int s, input logic [7:0] b);
		if (msg_fill[s] < MAX_PAYLOAD) begin
			msg_bytes[s][msg_fill[s]] = b;
			msg_fill[s]++;
		end
	endtask

	// A complete message leaves as chunks of eight bytes; the slot is freed afterward.
	task automatic emit_if_done(input int s);
		int n;
		int cnt;
		logic [63:0] bytes;
		n = msg_len[s];
		if (msg_fill[s] < n)
			return;
		for (int pos = 0; pos < n; pos += 8) begin
			cnt = (n - pos < 8) ? n - pos : 8;
			for (int j = 0; j < 8; j++)
				bytes[63 - 8 * j -: 8] = (j < cnt) ? msg_bytes[s][pos + j] : 8'h00;
			pending_chunks.push_back(make_chunk(bytes, 4'(cnt), pos + 8 >= n, 9'(n)));
		end
		release_slot(s);
	endtask

	// Update the local slot table for one accepted frame and queue the chunks it completes.
	task automatic predict_frame(input canseg_pkg::frame_t f);
		logic [7:0] d [8];
		int n;
		int s;
		int total;
		d = '{f.data_0, f.data_1, f.data_2, f.data_3, f.data_4, f.data_5, f.data_6, f.data_7};
		if (f.cmd == canseg_pkg::CMD_CLEAR) begin
			for (int k = 0; k < SLOTS; k++)
				release_slot(k);
			return;
		end
		n = (f.frame_len > canseg_pkg::FRAME_BYTES) ? int'(canseg_pkg::FRAME_BYTES)
			: int'(f.frame_len);
		if (n < 1 || d[0] == canseg_pkg::SEG_SINGLE)
			return;
		if (d[0] == canseg_pkg::SEG_START) begin
			if (n < canseg_pkg::START_HDR)
				return;
			total = int'({d[1], d[2]} & {5'd0, canseg_pkg::LEN_MASK});
			if (total == 0 || total > MAX_PAYLOAD)
				return;
			// Same key first, then the first free slot, else slot 0 is evicted.
			s = find_stream(f.frame_id);
			if (s < 0) begin
				for (int k = SLOTS - 1; k >= 0; k--)
					if (!stream_open[k])
						s = k;
				if (s < 0) begin
					release_slot(0);
					s = 0;
				end
			end
			stream_id[s] = f.frame_id;
			stream_open[s] = 1'b1;
			msg_len[s] = 9'(total);
			seg_expected[s] = 8'd1;
			msg_fill[s] = '0;
			for (int i = canseg_pkg::START_HDR; i < n; i++)
				append_byte(s, d[i]);
			emit_if_done(s);
		end else begin
			s = find_stream(f.frame_id);
			if (s < 0)
				return;
			if (d[0] != seg_expected[s]) begin
				release_slot(s);
				return;
			end
			for (int i = canseg_pkg::CONT_HDR; i < n; i++)
				append_byte(s, d[i]);
			seg_expected[s] = d[0] + 8'd1;
			emit_if_done(s);
		end
	endtask

	// Offer one frame after a random gap, hold it until the transfer, then withdraw it.
	task automatic send_frame(input canseg_pkg::frame_t f, input bit typed = 1'b0,
			input canseg_pkg::chunk_t c = '0);
		int gap;
		int before_n;
		pick_gap(tx_calm, gap);
		@(negedge clk);
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame <= f;
		frame_valid <= 1'b1;
		do
			@(posedge clk);
		while (!frame_ready);
		before_n = pending_chunks.size();
		predict_frame(f);
		if (typed) begin
			while (pending_chunks.size() > before_n)
				void'(pending_chunks.pop_back());
			pending_chunks.push_back(c);
		end
		frames_sent++;
		@(negedge clk);
		frame_valid <= 1'b0;
	endtask

	// One message as a start frame plus continuations; a few segments are corrupted.
	task automatic build_message(input logic [28:0] id, ref canseg_pkg::frame_t q[$]);
		int total;
		int n;
		int have;
		int seg;
		logic [7:0] d1;
		logic [63:0] bytes;
		total = ($urandom_range(0, 19) == 0) ? $urandom_range(200, MAX_PAYLOAD)
			: $urandom_range(1, 40);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(3, 8);
		d1 = 8'(total >> 8);
		if ($urandom_range(0, 4) == 0)
			d1 = d1 | (8'($urandom) & 8'hF8);
		bytes = {$urandom, $urandom};
		bytes[63:40] = {canseg_pkg::SEG_START, d1, 8'(total)};
		q.push_back(make_frame(canseg_pkg::CMD_FEED, id, 4'(n), bytes));
		have = ((n > 8) ? 8 : n) - 3;
		seg = 1;
		while (have < total && seg < 255) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
			bytes = {$urandom, $urandom};
			bytes[63:56] = ($urandom_range(0, 24) == 0) ? 8'(seg + $urandom_range(1, 254))
				: 8'(seg);
			q.push_back(make_frame(canseg_pkg::CMD_FEED, id, 4'(n), bytes));
			have += ((n > 8) ? 8 : n) - 1;
			seg++;
		end
	endtask

	// Receiver: after each transfer it may stall for a random gap, and once holds off for a long stretch.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				chunk_ready <= 1'b0;
				rx_hold--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_hold = LONG_HOLD - 1;
				chunk_ready <= 1'b0;
			end else begin
				chunk_ready <= 1'b1;
			end
		end
	end

	// Compare each output transfer with the oldest pending chunk.
	always @(posedge clk) begin : check_chunks
		canseg_pkg::chunk_t want;
		logic [63:0] got_bytes;
		logic [63:0] want_bytes;
		if (arst_n && chunk_valid && chunk_ready) begin
			if (pending_chunks.size() == 0) begin
				report_mismatch("chunk with nothing pending", chunk.message_length, 0);
			end else begin
				want = pending_chunks.pop_front();
				got_bytes = chunk[77:14];
				want_bytes = want[77:14];
				for (int j = 0; j < 8; j++)
					if (got_bytes[63 - 8 * j -: 8] !== want_bytes[63 - 8 * j -: 8])
						report_mismatch($sformatf("out_byte_%0d", j),
							got_bytes[63 - 8 * j -: 8], want_bytes[63 - 8 * j -: 8]);
				if (chunk.chunk_count !== want.chunk_count)
					report_mismatch("chunk_count", chunk.chunk_count, want.chunk_count);
				if (chunk.last_chunk !== want.last_chunk)
					report_mismatch("last_chunk", chunk.last_chunk, want.last_chunk);
				if (chunk.message_length !== want.message_length)
					report_mismatch("message_length", chunk.message_length,
						want.message_length);
			end
			pick_gap(rx_calm, rx_hold);
		end
	end

	// Watchdog for a hung block or chunks that never arrive.
	initial begin
		#40_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		canseg_pkg::frame_t qa[$];
		canseg_pkg::frame_t qb[$];
		canseg_pkg::frame_t wrap_start;
		logic [28:0] wrap_id;
		logic [63:0] bytes;
		int r;
		int random_goal;
		bit paused_midway;
		clk = 1'b0;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		chunk_ready = 1'b0;
		paused_midway = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			stream_id[s] = '0;
			release_slot(s);
		end
		id_pool[0] = 29'h0;
		id_pool[1] = 29'h1FFFFFFF;
		for (int k = 2; k < 8; k++)
			id_pool[k] = 29'($urandom);

		// Directed table: ignored frames, extremes, multi-chunk, wrong segment, eviction.
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_CLEAR, 29'h0, 4'd0, 64'h0),
			1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1, 4'd0,
			64'h00_00_05_11_22_33_44_55), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1, 4'd8,
			64'hFF_00_05_11_22_33_44_55), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1, 4'd2,
			64'h00_00_05_11_22_33_44_55), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1, 4'd8,
			64'h00_00_00_11_22_33_44_55), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1, 4'd8,
			64'h00_01_01_11_22_33_44_55), 1'b0, '0});
		// High bits of the length field are masked off, leaving five bytes.
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h1FFFFFFF, 4'd8,
			64'h00_F8_05_A1_A2_A3_A4_A5), 1'b1,
			make_chunk(64'hA1_A2_A3_A4_A5_00_00_00, 4'd5, 1'b1, 9'd5)});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0, 4'd4,
			64'h00_00_01_5A_FF_FF_FF_FF), 1'b1,
			make_chunk(64'h5A_00_00_00_00_00_00_00, 4'd1, 1'b1, 9'd1)});
		// A frame length above eight counts as eight.
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0ABCDEF, 4'd15,
			64'h00_00_05_01_02_03_04_05), 1'b1,
			make_chunk(64'h01_02_03_04_05_00_00_00, 4'd5, 1'b1, 9'd5)});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h123, 4'd8,
			64'h01_11_22_33_44_55_66_77), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h155, 4'd8,
			64'h00_00_08_00_FF_00_FF_AA), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h155, 4'd4,
			64'h01_55_00_FF_12_34_56_78), 1'b1,
			make_chunk(64'h00_FF_00_FF_AA_55_00_FF, 4'd8, 1'b1, 9'd8)});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0AAAAAAA, 4'd8,
			64'h00_00_14_10_11_12_13_14), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0AAAAAAA, 4'd8,
			64'h01_20_21_22_23_24_25_26), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0AAAAAAA, 4'd8,
			64'h02_30_31_32_33_34_35_36), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h0AAAAAAA, 4'd2,
			64'h03_40_41_42_43_44_45_46), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h2, 4'd3,
			64'h00_00_1E_00_00_00_00_00), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h2, 4'd8,
			64'h05_01_02_03_04_05_06_07), 1'b0, '0});
		directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'h2, 4'd8,
			64'h01_01_02_03_04_05_06_07), 1'b0, '0});
		// Seven open streams for six slots: the last one evicts slot 0.
		for (int k = 0; k < 7; k++)
			directed_rows.push_back('{make_frame(canseg_pkg::CMD_FEED, 29'(16 + k), 4'd3,
				64'h00_00_64_00_00_00_00_00), 1'b0, '0});

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_frame(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].c);
		while (pending_chunks.size() != 0)
			@(posedge clk);

		// Random part; the receiver starts with a long hold so the block backs up.
		long_hold_req = 1'b1;
		random_goal = frames_sent + RANDOM_ITEMS;
		while (frames_sent < random_goal) begin
			if (!paused_midway && frames_sent >= random_goal - RANDOM_ITEMS / 2) begin
				paused_midway = 1'b1;
				while (pending_chunks.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			qa.delete();
			qb.delete();
			if (r < 60) begin
				build_message(pick_id(), qa);
				foreach (qa[i])
					send_frame(qa[i]);
			end else if (r < 75) begin
				// Two streams with their frames interleaved.
				build_message(pick_id(), qa);
				build_message(pick_id(), qb);
				while (qa.size() != 0 || qb.size() != 0) begin
					if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
						send_frame(qa.pop_front());
					else
						send_frame(qb.pop_front());
				end
			end else if (r < 88) begin
				bytes = {$urandom, $urandom};
				if ($urandom_range(0, 1) == 1)
					bytes[63:56] = 8'($urandom_range(0, 3));
				send_frame(make_frame(($urandom_range(0, 15) == 0) ? canseg_pkg::CMD_CLEAR
					: canseg_pkg::CMD_FEED, pick_id(), 4'($urandom_range(0, 15)), bytes));
			end else if (r < 93) begin
				send_frame(make_frame(canseg_pkg::CMD_CLEAR, 29'($urandom), 4'($urandom),
					{$urandom, $urandom}));
			end else begin
				// An opened stream that is never finished keeps its slot busy.
				build_message(pick_id(), qa);
				send_frame(qa[0]);
			end
		end

		// Long stream of empty continuations up to the last segment number.
		wrap_id = 29'h0F0F0F0;
		wrap_start = make_frame(canseg_pkg::CMD_FEED, wrap_id, 4'd3,
			64'h00_01_00_00_00_00_00_00);
		send_frame(wrap_start);
		for (int seg = 1; seg < 255; seg++)
			send_frame(make_frame(canseg_pkg::CMD_FEED, wrap_id, 4'd1,
				{8'(seg), 24'($urandom), $urandom}));
		send_frame(make_frame(canseg_pkg::CMD_FEED, wrap_id, 4'd8,
			{canseg_pkg::SEG_SINGLE, 24'($urandom), $urandom}));
		send_frame(make_frame(canseg_pkg::CMD_FEED, wrap_id, 4'd8,
			{8'hFE, 24'($urandom), $urandom}));

		@(negedge clk);
		frame_valid <= 1'b0;
		while (pending_chunks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/canseg_pkg.sv
design/can_segment_reassembler.sv
tb/testbench.sv
